// File: rtl/i2cm_pkg.sv
// Shared types and constants of the I2C master bit sequencer.
package i2cm_pkg;

  // Operation codes carried in the input word
  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_START    = 3'd1;
  localparam logic [2:0] OP_STOP     = 3'd2;
  localparam logic [2:0] OP_WRITE    = 3'd3;
  localparam logic [2:0] OP_READ     = 3'd4;
  localparam logic [2:0] OP_WAIT_ACK = 3'd5;

  localparam logic [15:0] DELAY_RESET = 16'd5;
  localparam logic [7:0]  MSB_MASK    = 8'h80;

  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 16;

  typedef enum logic [4:0] {
    PH_IDLE = 5'd0,
    PH_S0   = 5'd1,
    PH_S1   = 5'd2,
    PH_P0   = 5'd3,
    PH_P1   = 5'd4,
    PH_W0   = 5'd5,
    PH_W1   = 5'd6,
    PH_W2   = 5'd7,
    PH_WB0  = 5'd8,
    PH_WB1  = 5'd9,
    PH_WB2  = 5'd10,
    PH_RB0  = 5'd11,
    PH_RB1  = 5'd12,
    PH_RA0  = 5'd13,
    PH_RA1  = 5'd14,
    PH_RA2  = 5'd15
  } phase_t;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] data_byte;
    logic       send_ack;
    logic       sda_sample;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_seen;
    logic       rejected;
  } result_t;

endpackage

// File: rtl/i2cm_in_stage.sv
// Input register stage of the I2C master bit sequencer.
module i2cm_in_stage import i2cm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  take,
  output logic  item_valid_r,
  output item_t item_r
);

  logic item_valid_nxt;
  logic in_fire;

  // Accept a word when empty or when the held one moves on this cycle
  assign in_ready = !item_valid_r || take;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    item_valid_nxt = item_valid_r;
    if (in_fire) begin
      item_valid_nxt = 1'b1;
    end else if (take) begin
      item_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
    end
  end

  // Payload loads on accept only
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_item;
    end
  end

endmodule

// File: rtl/i2cm_seq_core.sv
// Sequencer state, delay counter and per-word result logic.
module i2cm_seq_core import i2cm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  item_t       item,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  output result_t     res
);

  phase_t      phase_r, phase_nxt;
  logic [3:0]  bit_index_r, bit_index_nxt;
  logic [7:0]  shift_byte_r, shift_byte_nxt;
  logic [15:0] delay_left_r, delay_left_nxt;
  logic [15:0] delay_ticks_r;
  logic        ack_choice_r, ack_choice_nxt;
  logic        line_scl_r, line_scl_nxt;
  logic        line_sda_r, line_sda_nxt;
  logic        line_drive_r, line_drive_nxt;
  logic        ack_flag_r, ack_flag_nxt;
  logic [7:0]  read_result_r, read_result_nxt;

  logic        busy_now;
  logic        is_cmd;
  logic        cmd_go;
  logic        tick_busy;
  logic        adv;
  logic [15:0] delay_dec;
  logic [15:0] delay_load;
  logic [3:0]  bit_inc;
  logic [7:0]  shift_wr;
  logic [7:0]  shift_rd;

  // Decode the word against the current state
  assign busy_now   = (phase_r != PH_IDLE);
  assign is_cmd     = (item.operation >= OP_START) && (item.operation <= OP_WAIT_ACK);
  assign cmd_go     = is_cmd && !busy_now;
  assign tick_busy  = (item.operation == OP_TICK) && busy_now;
  assign delay_dec  = delay_left_r - {15'd0, (delay_left_r != 16'd0)};
  assign adv        = tick_busy && (delay_dec == 16'd0);
  assign delay_load = (delay_ticks_r == 16'd0) ? 16'd1 : delay_ticks_r;
  assign bit_inc    = bit_index_r + 4'd1;
  assign shift_wr   = {shift_byte_r[6:0], 1'b0};
  assign shift_rd   = {shift_byte_r[6:0], item.sda_sample};

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (cmd_go) begin
      case (item.operation)
        OP_START:    phase_nxt = PH_S0;
        OP_STOP:     phase_nxt = PH_P0;
        OP_WRITE:    phase_nxt = PH_WB0;
        OP_READ:     phase_nxt = PH_RB0;
        OP_WAIT_ACK: phase_nxt = PH_W0;
        default:     phase_nxt = phase_r;
      endcase
    end else if (adv) begin
      case (phase_r)
        PH_S0:   phase_nxt = PH_S1;
        PH_S1:   phase_nxt = PH_IDLE;
        PH_P0:   phase_nxt = PH_P1;
        PH_P1:   phase_nxt = PH_IDLE;
        PH_W0:   phase_nxt = PH_W1;
        PH_W1:   phase_nxt = PH_W2;
        PH_W2:   phase_nxt = PH_IDLE;
        PH_WB0:  phase_nxt = PH_WB1;
        PH_WB1:  phase_nxt = PH_WB2;
        PH_WB2:  phase_nxt = bit_inc[3] ? PH_IDLE : PH_WB0;
        PH_RB0:  phase_nxt = PH_RB1;
        PH_RB1:  phase_nxt = bit_inc[3] ? PH_RA0 : PH_RB0;
        PH_RA0:  phase_nxt = PH_RA1;
        PH_RA1:  phase_nxt = PH_RA2;
        PH_RA2:  phase_nxt = PH_IDLE;
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  // Line levels, shift register, counters
  always_comb begin
    bit_index_nxt   = bit_index_r;
    shift_byte_nxt  = shift_byte_r;
    ack_choice_nxt  = ack_choice_r;
    line_scl_nxt    = line_scl_r;
    line_sda_nxt    = line_sda_r;
    line_drive_nxt  = line_drive_r;
    ack_flag_nxt    = ack_flag_r;
    read_result_nxt = read_result_r;
    delay_left_nxt  = delay_left_r;

    if (cmd_go) begin
      bit_index_nxt = 4'd0;
      case (item.operation)
        OP_START: begin
          line_drive_nxt = 1'b1;
          line_sda_nxt   = 1'b1;
          line_scl_nxt   = 1'b1;
        end
        OP_STOP: begin
          line_drive_nxt = 1'b1;
          line_sda_nxt   = 1'b0;
          line_scl_nxt   = 1'b1;
        end
        OP_WRITE: begin
          shift_byte_nxt = item.data_byte;
          line_drive_nxt = 1'b1;
          line_sda_nxt   = ((item.data_byte & MSB_MASK) != 8'd0);
        end
        OP_READ: begin
          shift_byte_nxt = 8'd0;
          ack_choice_nxt = item.send_ack;
          line_drive_nxt = 1'b0;
          line_scl_nxt   = 1'b1;
        end
        OP_WAIT_ACK: begin
          line_drive_nxt = 1'b0;
        end
        default: begin
          line_drive_nxt = line_drive_r;
        end
      endcase
    end else if (adv) begin
      case (phase_r)
        PH_S0:  line_sda_nxt = 1'b0;
        PH_S1:  line_scl_nxt = 1'b0;
        PH_P0:  line_sda_nxt = 1'b1;
        PH_W0:  line_scl_nxt = 1'b1;
        PH_W1: begin
          ack_flag_nxt = !item.sda_sample;
          line_scl_nxt = 1'b0;
        end
        PH_W2:  line_drive_nxt = 1'b1;
        PH_WB0: line_scl_nxt = 1'b1;
        PH_WB1: line_scl_nxt = 1'b0;
        PH_WB2: begin
          shift_byte_nxt = shift_wr;
          bit_index_nxt  = bit_inc;
          if (!bit_inc[3]) begin
            line_drive_nxt = 1'b1;
            line_sda_nxt   = ((shift_wr & MSB_MASK) != 8'd0);
          end
        end
        PH_RB0: begin
          shift_byte_nxt = shift_rd;
          line_scl_nxt   = 1'b0;
        end
        PH_RB1: begin
          bit_index_nxt = bit_inc;
          if (bit_inc[3]) begin
            line_drive_nxt = 1'b1;
            line_sda_nxt   = !ack_choice_r;
          end else begin
            line_scl_nxt = 1'b1;
          end
        end
        PH_RA0: line_scl_nxt    = 1'b1;
        PH_RA1: line_scl_nxt    = 1'b0;
        PH_RA2: read_result_nxt = shift_byte_r;
        default: line_scl_nxt   = line_scl_r;
      endcase
    end

    // Reload the interval on every step, clear it when going idle
    if (cmd_go || adv) begin
      delay_left_nxt = (phase_nxt == PH_IDLE) ? 16'd0 : delay_load;
    end else if (tick_busy) begin
      delay_left_nxt = delay_dec;
    end
  end

  // Result for this word
  always_comb begin
    res.scl_level = line_scl_nxt;
    res.sda_level = line_drive_nxt & line_sda_nxt;
    res.sda_drive = line_drive_nxt;
    res.busy_res  = (phase_nxt != PH_IDLE);
    res.done_res  = adv && (phase_nxt == PH_IDLE);
    res.read_data = read_result_nxt;
    res.ack_seen  = ack_flag_nxt;
    res.rejected  = is_cmd && busy_now;
  end

  // Commit state when a word passes through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      bit_index_r   <= 4'd0;
      shift_byte_r  <= 8'd0;
      delay_left_r  <= 16'd0;
      ack_choice_r  <= 1'b0;
      line_scl_r    <= 1'b1;
      line_sda_r    <= 1'b1;
      line_drive_r  <= 1'b1;
      ack_flag_r    <= 1'b0;
      read_result_r <= 8'd0;
    end else if (step) begin
      phase_r       <= phase_nxt;
      bit_index_r   <= bit_index_nxt;
      shift_byte_r  <= shift_byte_nxt;
      delay_left_r  <= delay_left_nxt;
      ack_choice_r  <= ack_choice_nxt;
      line_scl_r    <= line_scl_nxt;
      line_sda_r    <= line_sda_nxt;
      line_drive_r  <= line_drive_nxt;
      ack_flag_r    <= ack_flag_nxt;
      read_result_r <= read_result_nxt;
    end
  end

  // Delay interval register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_ticks_r <= DELAY_RESET;
    end else if (cfg_we) begin
      delay_ticks_r <= cfg_data;
    end
  end

endmodule

// File: rtl/i2cm_out_stage.sv
// Result register stage of the I2C master bit sequencer.
module i2cm_out_stage import i2cm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res_in,
  output logic    can_load,
  output logic    out_valid_r,
  input  logic    out_ready,
  output result_t res_r
);

  logic out_valid_nxt;

  // Free when empty or when the held word leaves this cycle
  assign can_load = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

endmodule

// File: rtl/i2c_master_bit_sequencer.sv
// I2C master bit sequencer: top level with stream channels and delay register.
//
// Input words carry a command or a tick in in_tuser; commands are taken only
// while idle, ticks advance a running command by one count of the bus delay.
// Each input word yields exactly one result word on the out_ channel with the
// SCL/SDA levels to drive, the SDA drive enable, busy/done flags, the last
// received byte, the last ACK seen and a rejected flag for a busy command.
// cfg_data sets the number of ticks per bus delay interval (0 acts as 1);
// cfg_ready is always high and writes belong to idle periods.
// Path: an accepted word is registered in the input stage, then processed and
// its result registered in the output stage, which drives out_tvalid.
// Throughput: one word per cycle unless out_tready stalls; the state update is
// one pass of phase decode and 16-bit delay decrement between both registers.
// Reset: sequencer idle, SCL and SDA driven high, delay interval 5 ticks,
// both register stages empty.
// Stall: while out_tready is low the result holds, the input register fills
// with one more word and in_tready then drops until the result is taken.
module i2c_master_bit_sequencer import i2cm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // [2:0] operation
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  // [7:0] data_byte, [8] send_ack, [9] sda_sample, [15:10] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [0] scl_level, [1] sda_level, [2] sda_drive, [3] busy_res, [4] done_res,
  // [12:5] read_data, [13] ack_seen, [14] rejected, [15] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [15:0]            cfg_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready
);

  item_t   in_item;
  item_t   item_r;
  logic    item_valid_r;
  logic    can_load;
  logic    step;
  result_t res;
  result_t res_r;

  // Unpack the input word
  always_comb begin
    in_item.operation  = in_tuser[2:0];
    in_item.data_byte  = in_tdata[7:0];
    in_item.send_ack   = in_tdata[8];
    in_item.sda_sample = in_tdata[9];
  end

  assign cfg_ready = 1'b1;
  assign step      = item_valid_r && can_load;

  i2cm_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_item      (in_item),
    .take         (step),
    .item_valid_r (item_valid_r),
    .item_r       (item_r)
  );

  i2cm_seq_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .item     (item_r),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .res      (res)
  );

  i2cm_out_stage u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (step),
    .res_in      (res),
    .can_load    (can_load),
    .out_valid_r (out_tvalid),
    .out_ready   (out_tready),
    .res_r       (res_r)
  );

  // Pack the result word
  assign out_tdata = {1'b0, res_r.rejected, res_r.ack_seen, res_r.read_data,
                      res_r.done_res, res_r.busy_res, res_r.sda_drive,
                      res_r.sda_level, res_r.scl_level};

  // A finished command leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[4] |-> !out_tdata[3])
    else $error("done reported while still busy");

  // A rejected command cannot finish one on the same word
  a_rej_no_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[14] |-> !out_tdata[4] && out_tdata[3])
    else $error("rejected word also completed a command");

  // Released SDA reads as low level
  a_sda_released: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[2] |-> !out_tdata[1])
    else $error("sda level set while not driven");

  // An empty result stage never blocks the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with result stage empty");

endmodule

// File: bench/i2cm_checker.sv
`timescale 1ns / 100ps
// Checker for the I2C bit sequencer: tracks the bus state and compares every result word.
module i2cm_checker import i2cm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [15:0]            cfg_data,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  output int                     mismatches,
  output int                     pending,
  output logic                   seq_busy
);

  // Mirror of the sequencer state
  phase_t      ph;
  logic [15:0] delay_cfg;
  logic [15:0] delay_left;
  logic [3:0]  bit_idx;
  logic [7:0]  shreg;
  logic [7:0]  rx_byte;
  logic        ack_sel;
  logic        scl;
  logic        sda;
  logic        drv;
  logic        ack_flag;

  result_t     expected_words[$];
  result_t     want;
  result_t     next_word;
  item_t       in_word;
  int          err_count;

  initial begin
    err_count = 0;
  end

  // Enter a phase and load one full bus delay interval (zero counts as one)
  task automatic load_interval(input phase_t nxt);
    ph         = nxt;
    delay_left = (delay_cfg == 16'd0) ? 16'd1 : delay_cfg;
  endtask

  // Advance the bus state by one input word and form its result word
  task automatic step_sequencer(input item_t it, output result_t r);
    logic done;
    logic rej;
    logic busy;
    done = 1'b0;
    rej  = 1'b0;
    busy = (ph != PH_IDLE);
    if (it.operation == OP_TICK) begin
      if (busy) begin
        if (delay_left != 16'd0) delay_left = delay_left - 16'd1;
        if (delay_left == 16'd0) begin
          case (ph)
            PH_S0: begin
              sda = 1'b0;
              load_interval(PH_S1);
            end
            PH_S1: begin
              scl = 1'b0;
              ph = PH_IDLE; delay_left = '0; done = 1'b1;
            end
            PH_P0: begin
              sda = 1'b1;
              load_interval(PH_P1);
            end
            PH_P1: begin
              ph = PH_IDLE; delay_left = '0; done = 1'b1;
            end
            PH_W0: begin
              scl = 1'b1;
              load_interval(PH_W1);
            end
            PH_W1: begin
              // ACK is a low level on the released line
              ack_flag = ~it.sda_sample;
              scl = 1'b0;
              load_interval(PH_W2);
            end
            PH_W2: begin
              drv = 1'b1;
              ph = PH_IDLE; delay_left = '0; done = 1'b1;
            end
            PH_WB0: begin
              scl = 1'b1;
              load_interval(PH_WB1);
            end
            PH_WB1: begin
              scl = 1'b0;
              load_interval(PH_WB2);
            end
            PH_WB2: begin
              shreg   = {shreg[6:0], 1'b0};
              bit_idx = bit_idx + 4'd1;
              if (bit_idx >= 4'd8) begin
                ph = PH_IDLE; delay_left = '0; done = 1'b1;
              end else begin
                drv = 1'b1;
                sda = ((shreg & MSB_MASK) != 8'd0);
                load_interval(PH_WB0);
              end
            end
            PH_RB0: begin
              shreg = {shreg[6:0], it.sda_sample};
              scl   = 1'b0;
              load_interval(PH_RB1);
            end
            PH_RB1: begin
              bit_idx = bit_idx + 4'd1;
              if (bit_idx >= 4'd8) begin
                // Answer ACK by pulling SDA low, NACK by driving it high
                drv = 1'b1;
                sda = ~ack_sel;
                load_interval(PH_RA0);
              end else begin
                scl = 1'b1;
                load_interval(PH_RB0);
              end
            end
            PH_RA0: begin
              scl = 1'b1;
              load_interval(PH_RA1);
            end
            PH_RA1: begin
              scl = 1'b0;
              load_interval(PH_RA2);
            end
            PH_RA2: begin
              rx_byte = shreg;
              ph = PH_IDLE; delay_left = '0; done = 1'b1;
            end
            default: begin
              ph = PH_IDLE;
              delay_left = '0;
            end
          endcase
        end
      end
    end else if (it.operation <= OP_WAIT_ACK) begin
      // Commands start only from idle; a busy sequencer flags and drops them
      if (busy) begin
        rej = 1'b1;
      end else begin
        bit_idx = 4'd0;
        case (it.operation)
          OP_START: begin
            drv = 1'b1; sda = 1'b1; scl = 1'b1;
            load_interval(PH_S0);
          end
          OP_STOP: begin
            drv = 1'b1; sda = 1'b0; scl = 1'b1;
            load_interval(PH_P0);
          end
          OP_WRITE: begin
            shreg = it.data_byte;
            drv   = 1'b1;
            sda   = ((it.data_byte & MSB_MASK) != 8'd0);
            load_interval(PH_WB0);
          end
          OP_READ: begin
            shreg   = 8'd0;
            ack_sel = it.send_ack;
            drv     = 1'b0;
            scl     = 1'b1;
            load_interval(PH_RB0);
          end
          default: begin
            drv = 1'b0;
            load_interval(PH_W0);
          end
        endcase
      end
    end
    r.scl_level  = scl;
    r.sda_level  = drv ? sda : 1'b0;
    r.sda_drive  = drv;
    r.busy_res   = (ph != PH_IDLE);
    r.done_res   = done;
    r.read_data  = rx_byte;
    r.ack_seen   = ack_flag;
    r.rejected   = rej;
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      err_count++;
    end
  endtask

  // Watch all three channels at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      ph         = PH_IDLE;
      delay_cfg  = DELAY_RESET;
      delay_left = '0;
      bit_idx    = '0;
      shreg      = '0;
      rx_byte    = '0;
      ack_sel    = 1'b0;
      scl        = 1'b1;
      sda        = 1'b1;
      drv        = 1'b1;
      ack_flag   = 1'b0;
      expected_words.delete();
    end else begin
      // Compare an accepted result word with the oldest expectation
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: result word with no expectation, actual %0h", $time, out_tdata);
          err_count++;
        end else begin
          want = expected_words.pop_front();
          check_field("scl_level", int'(want.scl_level), int'(out_tdata[0]));
          check_field("sda_level", int'(want.sda_level), int'(out_tdata[1]));
          check_field("sda_drive", int'(want.sda_drive), int'(out_tdata[2]));
          check_field("busy_res",  int'(want.busy_res),  int'(out_tdata[3]));
          check_field("done_res",  int'(want.done_res),  int'(out_tdata[4]));
          check_field("read_data", int'(want.read_data), int'(out_tdata[12:5]));
          check_field("ack_seen",  int'(want.ack_seen),  int'(out_tdata[13]));
          check_field("rejected",  int'(want.rejected),  int'(out_tdata[14]));
          check_field("pad bit",   0,                    int'(out_tdata[15]));
        end
      end
      if (cfg_valid && cfg_ready) delay_cfg = cfg_data;
      // Predict the result of an accepted input word
      if (in_tvalid && in_tready) begin
        in_word.operation  = in_tuser;
        in_word.data_byte  = in_tdata[7:0];
        in_word.send_ack   = in_tdata[8];
        in_word.sda_sample = in_tdata[9];
        step_sequencer(in_word, next_word);
        expected_words.push_back(next_word);
      end
    end
    mismatches <= err_count;
    pending    <= expected_words.size();
    seq_busy   <= (ph != PH_IDLE);
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// Top of the bench: clock, reset, stimulus and stall generation, and the verdict.
module testbench;
  import i2cm_pkg::*;

  // Operation codes outside the command set
  localparam logic [2:0] OP_BAD_LO = 3'd6;
  localparam logic [2:0] OP_BAD_HI = 3'd7;

  // Sampling modes for SDA on tick words
  localparam int SDA_LOW  = 0;
  localparam int SDA_HIGH = 1;
  localparam int SDA_RAND = 2;

  logic                   clk;
  logic                   rst_n;
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [15:0]            cfg_data;
  logic                   cfg_valid;
  logic                   cfg_ready;

  int   mismatches;
  int   pending;
  logic seq_busy;
  bit   fast;

  i2c_master_bit_sequencer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_data   (cfg_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready)
  );

  i2cm_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_data   (cfg_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .mismatches (mismatches),
    .pending    (pending),
    .seq_busy   (seq_busy)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop for a hung run
  initial begin
    #60_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  // Idle length: mostly none, some short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (fast || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one word; call at a falling edge, returns at the accepting edge
  task automatic drive_item(input item_t it);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser  <= it.operation;
    in_tdata  <= {6'd0, it.sda_sample, it.send_ack, it.data_byte};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_op(input logic [2:0] op, input logic [7:0] data,
                         input logic ack, input logic sda_in);
    item_t it;
    it.operation  = op;
    it.data_byte  = data;
    it.send_ack   = ack;
    it.sda_sample = sda_in;
    @(negedge clk);
    drive_item(it);
  endtask

  // Tick until the running command completes, then drop valid
  task automatic run_to_idle(input int sda_mode);
    item_t it;
    forever begin
      @(negedge clk);
      if (!seq_busy) break;
      it.operation  = OP_TICK;
      it.data_byte  = 8'($urandom);
      it.send_ack   = 1'($urandom);
      it.sda_sample = (sda_mode == SDA_RAND) ? 1'($urandom) : (sda_mode == SDA_HIGH);
      drive_item(it);
    end
    in_tvalid <= 1'b0;
  endtask

  // Write the delay register once the sequencer and the pipeline are empty
  task automatic set_delay(input logic [15:0] ticks);
    run_to_idle(SDA_RAND);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_data  <= ticks;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed command runs with random bytes and samples, plus noise
  task automatic run_random(input int count);
    item_t it;
    int    r;
    for (int k = 0; k < count; k++) begin
      @(negedge clk);
      r = $urandom_range(0, 99);
      it.data_byte  = 8'($urandom);
      it.send_ack   = 1'($urandom);
      it.sda_sample = 1'($urandom);
      if (seq_busy) begin
        if (r < 88)      it.operation = OP_TICK;
        else if (r < 94) it.operation = 3'($urandom_range(OP_START, OP_WAIT_ACK));
        else             it.operation = 3'($urandom_range(OP_BAD_LO, OP_BAD_HI));
      end else begin
        if (r < 55)      it.operation = 3'($urandom_range(OP_START, OP_WAIT_ACK));
        else if (r < 80) it.operation = OP_TICK;
        else             it.operation = 3'($urandom_range(OP_BAD_LO, OP_BAD_HI));
      end
      drive_item(it);
    end
  endtask

  // Result side: hold ready mostly high, stall now and then
  initial begin : ready_gen
    int s;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      s = (!fast && $urandom_range(0, 99) < 20) ? gap_len() : 0;
      if (s == 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        repeat (s - 1) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [15:0] delay_set[7];
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = '0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    fast      = 1'b0;
    delay_set = '{16'd1, 16'd2, 16'd0, 16'd3, 16'd1, 16'd4, 16'd2};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset delay: idle tick, unknown codes, start with a busy command, stop
    send_op(OP_TICK, 8'h00, 1'b0, 1'b0);
    send_op(OP_BAD_LO, 8'hFF, 1'b1, 1'b1);
    send_op(OP_BAD_HI, 8'h00, 1'b0, 1'b1);
    send_op(OP_START, 8'h00, 1'b0, 1'b0);
    repeat (3) send_op(OP_TICK, 8'h00, 1'b0, 1'b1);
    send_op(OP_WRITE, 8'h3C, 1'b0, 1'b0);
    run_to_idle(SDA_RAND);
    send_op(OP_STOP, 8'hFF, 1'b1, 1'b1);
    run_to_idle(SDA_RAND);

    // Shortest delay: byte extremes, reads with ACK and NACK, both ACK levels
    set_delay(16'd1);
    send_op(OP_WRITE, 8'hFF, 1'b1, 1'b1);
    send_op(OP_TICK, 8'h00, 1'b0, 1'b0);
    send_op(OP_BAD_LO, 8'h00, 1'b0, 1'b0);
    send_op(OP_READ, 8'h00, 1'b1, 1'b0);
    run_to_idle(SDA_RAND);
    send_op(OP_WRITE, 8'h00, 1'b0, 1'b0);
    run_to_idle(SDA_RAND);
    send_op(OP_WRITE, 8'hA5, 1'b0, 1'b1);
    run_to_idle(SDA_RAND);
    send_op(OP_READ, 8'h00, 1'b1, 1'b0);
    run_to_idle(SDA_HIGH);
    send_op(OP_READ, 8'hFF, 1'b0, 1'b1);
    run_to_idle(SDA_LOW);
    send_op(OP_READ, 8'h00, 1'b1, 1'b1);
    run_to_idle(SDA_RAND);
    send_op(OP_WAIT_ACK, 8'h00, 1'b0, 1'b1);
    run_to_idle(SDA_LOW);
    send_op(OP_WAIT_ACK, 8'h00, 1'b0, 1'b0);
    run_to_idle(SDA_HIGH);

    // Zero delay acts as one
    set_delay(16'd0);
    send_op(OP_START, 8'h00, 1'b0, 1'b0);
    run_to_idle(SDA_RAND);
    send_op(OP_WAIT_ACK, 8'h00, 1'b0, 1'b0);
    run_to_idle(SDA_LOW);

    // Random runs across several small delays
    foreach (delay_set[i]) begin
      set_delay(delay_set[i]);
      run_random(230);
      run_to_idle(SDA_RAND);
    end

    // Longest delay: one start, run back to back with no stalls, left running
    set_delay(16'hFFFF);
    fast = 1'b1;
    send_op(OP_START, 8'h00, 1'b0, 1'b0);
    repeat (100) send_op(OP_TICK, 8'h00, 1'b0, 1'b1);
    send_op(OP_STOP, 8'h00, 1'b0, 1'b0);
    send_op(OP_BAD_HI, 8'h00, 1'b0, 1'b0);
    @(negedge clk);
    in_tvalid <= 1'b0;
    fast = 1'b0;

    // Drain and report
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
